// ===== rtl/core/radix_literal_to_integer_defines.svh =====
// ---------------------------------------------------------------------------
// radix literal to integer: assertion macros
// clocked on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef RADIX_LITERAL_TO_INTEGER_DEFINES_SVH
`define RADIX_LITERAL_TO_INTEGER_DEFINES_SVH

// same-cycle implication
`define RLI_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RLI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rli_pkg.sv =====
// ---------------------------------------------------------------------------
// rli_pkg
// types and constants shared by the radix literal parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rli_pkg;

	typedef enum logic [1:0] {
		RADIX_BIN = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_HEX = 2'd2,
		RADIX_DEC = 2'd3
	} radix_t;

	// what the back end does with one character
	typedef enum logic [1:0] {
		CK_DIGIT = 2'd0,
		CK_SKIP  = 2'd1,
		CK_STOP  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		radix_t      mode;
		logic [3:0]  digit;
		logic        last;
	} rli_cmd_t;

	localparam int unsigned CMD_W = $bits(rli_cmd_t);
	localparam int unsigned RES_W = 65;

	localparam logic [6:0]  BIN_DIGIT_LIMIT = 7'd64;
	localparam logic [6:0]  OCT_DIGIT_LIMIT = 7'd22;
	localparam logic [6:0]  HEX_DIGIT_LIMIT = 7'd16;
	localparam logic [6:0]  DIGIT_COUNT_MAX = 7'd127;
	localparam logic [4:0]  DEC_POS_LIMIT   = 5'd19;
	localparam logic [4:0]  CHAR_POS_MAX    = 5'd31;
	localparam logic [63:0] SAT_VALUE       = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam logic [7:0]  CHAR_UNDERSCORE = 8'h5F;
	localparam logic [7:0]  CHAR_ZERO       = 8'h30;
	localparam logic [7:0]  CHAR_NINE       = 8'h39;
	// lower-case hex letter maps to its low nibble plus this, modulo 16
	localparam logic [3:0]  HEX_LETTER_ADJ  = 4'd9;

endpackage

`default_nettype wire

// ===== rtl/core/rli_fifo.sv =====
// ---------------------------------------------------------------------------
// rli_fifo
// small register queue with push/full and pop/empty
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "radix_literal_to_integer_defines.svh"

module rli_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2	// 2 or more
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`RLI_ASSERT_IMPLIES(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue count past depth")
	`RLI_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "lost push")
	`RLI_ASSERT_NEXT(a_count_down, do_pop && !do_push, count_q == $past(count_q) - 1'b1, "lost pop")
	`RLI_ASSERT_IMPLIES(a_ptr_empty, count_q == '0, wr_ptr_q == rd_ptr_q, "pointers apart when empty")

endmodule

`default_nettype wire

// ===== rtl/core/rli_front.sv =====
// ---------------------------------------------------------------------------
// rli_front
// radix register and character classification
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rli_front
	import rli_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] radix_mode,
	input  wire logic [7:0] character,
	input  wire logic       last_char,
	output rli_cmd_t        cmd
);

	radix_t radix_q;
	logic   is_dec_digit;
	logic   is_upper;
	logic   is_underscore;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_DEC;
		end else if (cfg_valid) begin
			radix_q <= radix_t'(radix_mode);
		end
	end

	assign is_dec_digit  = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
	assign is_underscore = (character == CHAR_UNDERSCORE);
	assign is_upper      = 1'b0;	// case folding leaves the low nibble alone

	always_comb begin
		cmd.mode  = radix_q;
		cmd.last  = last_char;
		cmd.digit = character[3:0];
		cmd.kind  = CK_DIGIT;
		if (is_underscore) begin
			cmd.kind = CK_SKIP;
		end else begin
			case (radix_q)
				RADIX_BIN: begin
					cmd.digit = {3'b000, character[0]};
				end
				RADIX_OCT: begin
					cmd.digit = {1'b0, character[2:0]};
				end
				RADIX_HEX: begin
					// letters: lower-cased code minus 'a' plus ten
					if (!is_dec_digit || is_upper) begin
						cmd.digit = character[3:0] + HEX_LETTER_ADJ;
					end
				end
				RADIX_DEC: begin
					if (!is_dec_digit) begin
						cmd.kind = CK_STOP;
					end
				end
				default: begin
					cmd.kind = CK_DIGIT;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rli_back.sv =====
// ---------------------------------------------------------------------------
// rli_back
// accumulator, counters and result formation
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rli_back
	import rli_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire rli_cmd_t  cmd,
	input  wire logic      cmd_valid,
	output logic           cmd_pop,
	input  wire logic      res_full,
	output logic           res_push,
	output logic [63:0]    res_value,
	output logic           res_sat
);

	logic [63:0] acc_q;
	logic [6:0]  dcount_q;
	logic [4:0]  cpos_q;
	logic        stopped_q;
	logic        ovf_q;

	logic        fire;
	logic        active;
	logic [63:0] acc_n;
	logic [6:0]  dcount_n;
	logic [6:0]  dcount_inc;
	logic [4:0]  cpos_n;
	logic        stopped_n;
	logic        ovf_n;

	assign fire     = cmd_valid && !res_full;
	assign cmd_pop  = fire;
	assign res_push = fire && cmd.last;

	assign cpos_n     = (cpos_q == CHAR_POS_MAX) ? cpos_q : cpos_q + 5'd1;
	assign dcount_inc = (dcount_q == DIGIT_COUNT_MAX) ? dcount_q : dcount_q + 7'd1;
	assign active     = !stopped_q && !ovf_q && (cmd.kind != CK_SKIP);

	always_comb begin
		acc_n     = acc_q;
		dcount_n  = dcount_q;
		stopped_n = stopped_q;
		ovf_n     = ovf_q;
		if (active) begin
			case (cmd.kind)
				CK_STOP: begin
					stopped_n = 1'b1;
				end
				CK_DIGIT: begin
					case (cmd.mode)
						RADIX_DEC: begin
							// times ten as eight plus two
							acc_n = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0}
								+ {60'd0, cmd.digit};
							ovf_n = (cpos_q > DEC_POS_LIMIT);
						end
						RADIX_BIN: begin
							acc_n    = {acc_q[62:0], cmd.digit[0]};
							dcount_n = dcount_inc;
							ovf_n    = (dcount_inc > BIN_DIGIT_LIMIT);
						end
						RADIX_OCT: begin
							acc_n    = {acc_q[60:0], cmd.digit[2:0]};
							dcount_n = dcount_inc;
							ovf_n    = (dcount_inc > OCT_DIGIT_LIMIT);
						end
						RADIX_HEX: begin
							acc_n    = {acc_q[59:0], cmd.digit};
							dcount_n = dcount_inc;
							ovf_n    = (dcount_inc > HEX_DIGIT_LIMIT);
						end
						default: begin
							acc_n = acc_q;
						end
					endcase
				end
				default: begin
					acc_n = acc_q;
				end
			endcase
		end
	end

	assign res_value = ovf_n ? SAT_VALUE : acc_n;
	assign res_sat   = ovf_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			dcount_q  <= '0;
			cpos_q    <= '0;
			stopped_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (fire) begin
			if (cmd.last) begin
				acc_q     <= '0;
				dcount_q  <= '0;
				cpos_q    <= '0;
				stopped_q <= 1'b0;
				ovf_q     <= 1'b0;
			end else begin
				acc_q     <= acc_n;
				dcount_q  <= dcount_n;
				cpos_q    <= cpos_n;
				stopped_q <= stopped_n;
				ovf_q     <= ovf_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/radix_literal_to_integer.sv =====
// ---------------------------------------------------------------------------
// radix_literal_to_integer
// turns the ascii characters of one numeric literal into a 64-bit integer
// ---------------------------------------------------------------------------
// usage
//   characters enter one per request on character/last_char, taken at an edge
//   with push high and full low; last_char marks the end of the literal
//   one result per literal (value, saturated) waits while empty is low and
//   leaves at an edge with pop high
//   radix_mode is written over cfg_valid/cfg_ready (always ready), by the user only
//   while idle (the block does not enforce it): 0 binary, 1 octal, 2 hex, 3 decimal
// timing
//   one character per cycle sustained while the result queue has room; the
//   accumulator update (shift or times-ten add) is the loop that sets this
//   a last character goes through the command queue; its result then waits in the result queue
// reset
//   radix goes to decimal, both queues empty, literal state cleared
// stalls
//   if pop stays low the result queue fills, the back end halts and the
//   command queue then raises full; nothing is dropped
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radix_literal_to_integer
	import rli_pkg::*;
#(
	parameter int unsigned CMD_DEPTH = 2,	// classified characters in flight
	parameter int unsigned RES_DEPTH = 2	// results awaiting pop
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  radix_mode,
	// character requests
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  character,
	input  wire logic        last_char,
	// results
	input  wire logic        pop,
	output logic             empty,
	output logic signed [63:0] value,
	output logic             saturated
);

	rli_cmd_t         front_cmd;
	rli_cmd_t         back_cmd;
	logic [CMD_W-1:0] back_cmd_bits;
	logic             cmd_empty;
	logic             cmd_pop;
	logic             res_full;
	logic             res_push;
	logic [63:0]      res_value;
	logic             res_sat;
	logic [RES_W-1:0] res_bits;

	// front: radix register and classification
	rli_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.radix_mode (radix_mode),
		.character  (character),
		.last_char  (last_char),
		.cmd        (front_cmd)
	);

	// decoupling queue between classification and the accumulator
	rli_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_cmd),
		.full    (full),
		.pop     (cmd_pop),
		.rd_data (back_cmd_bits),
		.empty   (cmd_empty)
	);

	assign back_cmd = rli_cmd_t'(back_cmd_bits);

	// back: literal state and result
	rli_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_valid (!cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_value (res_value),
		.res_sat   (res_sat)
	);

	// result queue keeps the back end running while the receiver stalls, until it fills
	rli_fifo #(
		.WIDTH (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data ({res_sat, res_value}),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_bits),
		.empty   (empty)
	);

	assign value     = signed'(res_bits[63:0]);
	assign saturated = res_bits[64];

endmodule

`default_nettype wire

// ===== bench/tb_radix_literal_to_integer.sv =====
// ---------------------------------------------------------------------------
// tb_radix_literal_to_integer
// self-checking bench for the radix literal parser: characters are queued in
// with random gaps, results are popped under random stalls, and every popped
// value and saturation flag is compared with a cycle-free model of the parse
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_radix_literal_to_integer;

	import rli_pkg::*;

	// cycles with no handshake of any kind before the run is abandoned
	localparam int unsigned STALL_LIMIT   = 2000;
	// characters in the random part
	localparam int unsigned RANDOM_CHARS  = 600;
	// characters per radix setting in the random part
	localparam int unsigned PHASE_CHARS   = 80;
	// result latency plus queue depth, with margin
	localparam int unsigned SETTLE_CYCLES = 8;

	// -----------------------------------------------------------------------
	// scoreboard: models the parse of each accepted character and holds the
	// results that are still to be popped
	// -----------------------------------------------------------------------
	class literal_scoreboard;

		localparam logic [7:0] CHAR_UPPER_A = 8'h41;
		localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
		localparam logic [7:0] CHAR_LOWER_A = 8'h61;
		localparam logic [7:0] CASE_OFFSET  = 8'h20;

		typedef struct packed {
			logic [63:0] value;
			logic        sat;
		} lit_result_t;

		radix_t        radix;
		logic [63:0]   acc;
		int unsigned   digits;
		int unsigned   position;
		bit            stopped;
		bit            over;
		lit_result_t   awaiting[$];
		int unsigned   errors;
		int unsigned   chars_taken;
		int unsigned   literals_checked;
		int unsigned   sat_seen;

		function new();
			radix = RADIX_DEC;
			errors = 0;
			chars_taken = 0;
			literals_checked = 0;
			sat_seen = 0;
			clear_literal();
		endfunction

		function void clear_literal();
			acc = '0;
			digits = 0;
			position = 0;
			stopped = 0;
			over = 0;
		endfunction

		function void set_radix(radix_t m);
			radix = m;
		endfunction

		function int unsigned pending();
			return awaiting.size();
		endfunction

		// one accepted character; a last character queues the literal's result
		function void note_char(logic [7:0] c, logic last);
			int unsigned at;
			int unsigned limit;
			logic [7:0]  lc;
			logic [3:0]  nib;
			lit_result_t r;
			chars_taken++;
			at = position;
			if (position < CHAR_POS_MAX)
				position++;
			if (!(stopped || over || c == CHAR_UNDERSCORE)) begin
				lc = c - CHAR_ZERO;
				case (radix)
					RADIX_DEC: begin
						if (c < CHAR_ZERO || c > CHAR_NINE)
							stopped = 1;
						else begin
							acc = acc * 64'd10 + 64'(lc);
							if (at > DEC_POS_LIMIT)
								over = 1;
						end
					end
					default: begin
						if (radix == RADIX_BIN) begin
							acc = {acc[62:0], lc[0]};
							limit = BIN_DIGIT_LIMIT;
						end else if (radix == RADIX_OCT) begin
							acc = {acc[60:0], lc[2:0]};
							limit = OCT_DIGIT_LIMIT;
						end else begin
							if (c >= CHAR_ZERO && c <= CHAR_NINE)
								nib = lc[3:0];
							else begin
								lc = c;
								if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
									lc = c + CASE_OFFSET;
								lc = lc - CHAR_LOWER_A + 8'd10;
								nib = lc[3:0];
							end
							acc = {acc[59:0], nib};
							limit = HEX_DIGIT_LIMIT;
						end
						if (digits < DIGIT_COUNT_MAX)
							digits++;
						if (digits > limit)
							over = 1;
					end
				endcase
			end
			if (last) begin
				r.value = over ? SAT_VALUE : acc;
				r.sat = over;
				awaiting.push_back(r);
				clear_literal();
			end
		endfunction

		task report(string msg);
			if (errors < 40)
				$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [63:0] got_value, logic got_sat);
			lit_result_t want;
			if (awaiting.size() == 0) begin
				report($sformatf("result %h sat %b popped with no literal open",
					got_value, got_sat));
				return;
			end
			want = awaiting.pop_front();
			literals_checked++;
			if (want.sat)
				sat_seen++;
			if (got_value !== want.value)
				report($sformatf("value %h, model %h", got_value, want.value));
			if (got_sat !== want.sat)
				report($sformatf("saturated %b, model %b", got_sat, want.sat));
		endtask

	endclass

	// -----------------------------------------------------------------------
	// signals and block
	// -----------------------------------------------------------------------
	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         radix_mode;
	logic               push;
	logic               full;
	logic [7:0]         character;
	logic               last_char;
	logic               pop;
	logic               empty;
	logic signed [63:0] value;
	logic               saturated;

	literal_scoreboard sb = new();

	// characters of the literal about to be sent
	logic [7:0]  lit_chars[$];
	int unsigned idle_cycles;

	radix_literal_to_integer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.radix_mode (radix_mode),
		.push       (push),
		.full       (full),
		.character  (character),
		.last_char  (last_char),
		.pop        (pop),
		.empty      (empty),
		.value      (value),
		.saturated  (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// monitor and watchdog: handshakes are sampled at the edge, before any
	// of this edge's drives land, so the pre-edge values decide acceptance
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				sb.check_result(value, saturated);
				idle_cycles = 0;
			end else if (push && !full) begin
				idle_cycles = 0;
			end else if (cfg_valid && cfg_ready) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			// a result leaving at this edge can never be from a request taken
			// at the same edge, so checking first keeps the queue in order
			if (push && !full)
				sb.note_char(character, last_char);
			if (cfg_valid && cfg_ready)
				sb.set_radix(radix_t'(radix_mode));
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// -----------------------------------------------------------------------
	// idle lengths: mostly none or short, now and then a long one
	// -----------------------------------------------------------------------
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// -----------------------------------------------------------------------
	// result side: random stalls, with the odd long stretch of pop held high
	// -----------------------------------------------------------------------
	initial begin
		int unsigned stall;
		pop = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 9) == 0) begin
				pop <= 1'b1;
				repeat ($urandom_range(30, 80)) @(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall != 0) begin
					pop <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				pop <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	// -----------------------------------------------------------------------
	// request side
	// -----------------------------------------------------------------------

	// one character: optional gap, then hold push until the block takes it
	task automatic send_char(input logic [7:0] c, input logic l, input bit eager);
		int unsigned gap;
		gap = eager ? 0 : pick_gap();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		character <= c;
		last_char <= l;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1, 1'b0);
	endtask

	task automatic send_literal();
		bit eager;
		// some literals go back to back with no gaps at all
		eager = ($urandom_range(0, 4) == 0);
		foreach (lit_chars[i])
			send_char(lit_chars[i], i == lit_chars.size() - 1, eager);
	endtask

	// stop sending, wait for every result, then let the pipe empty out;
	// waiting on the clock first so the monitor has noted the last request taken
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_radix(input radix_t m);
		cfg_valid <= 1'b1;
		radix_mode <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// a digit character that is valid in the given radix, letters in either case
	function automatic logic [7:0] pick_digit(input radix_t m);
		int unsigned d;
		case (m)
			RADIX_BIN: d = $urandom_range(0, 1);
			RADIX_OCT: d = $urandom_range(0, 7);
			RADIX_HEX: d = $urandom_range(0, 15);
			default:   d = $urandom_range(0, 9);
		endcase
		if (d < 10)
			return CHAR_ZERO + 8'(d);
		return ($urandom_range(0, 1) ? literal_scoreboard::CHAR_UPPER_A
			: literal_scoreboard::CHAR_LOWER_A) + 8'(d - 10);
	endfunction

	// fills lit_chars: mostly well-formed literals, some near or past the
	// digit limit, some with a stray byte, and a share of pure noise
	task automatic build_literal(input radix_t m);
		int unsigned len;
		int unsigned limit;
		int unsigned r;
		lit_chars.delete();
		if ($urandom_range(0, 99) < 22) begin
			repeat ($urandom_range(1, 8))
				lit_chars.push_back(8'($urandom_range(0, 255)));
			return;
		end
		case (m)
			RADIX_BIN: limit = BIN_DIGIT_LIMIT;
			RADIX_OCT: limit = OCT_DIGIT_LIMIT;
			RADIX_HEX: limit = HEX_DIGIT_LIMIT;
			default:   limit = DEC_POS_LIMIT + 1;
		endcase
		r = $urandom_range(0, 99);
		if (r < 60)
			len = $urandom_range(1, 6);
		else if (r < 88)
			len = $urandom_range(limit - 2, limit + 2);
		else
			len = $urandom_range(1, limit + 8);
		// a long run of underscores pushes the decimal position up to or near its cap
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(28, 34)) lit_chars.push_back(CHAR_UNDERSCORE);
		repeat (len) begin
			if ($urandom_range(0, 9) == 0)
				lit_chars.push_back(CHAR_UNDERSCORE);
			lit_chars.push_back(pick_digit(m));
		end
		if ($urandom_range(0, 9) == 0)
			lit_chars.insert($urandom_range(0, lit_chars.size() - 1),
				8'($urandom_range(0, 255)));
	endtask

	// -----------------------------------------------------------------------
	// main sequence
	// -----------------------------------------------------------------------
	initial begin
		radix_t      order[4];
		radix_t      m;
		int unsigned sent;
		int unsigned phase_sent;
		int unsigned phases;
		bit          held_once;
		order = '{RADIX_BIN, RADIX_OCT, RADIX_HEX, RADIX_DEC};
		sent = 0;
		phases = 0;
		held_once = 0;
		idle_cycles = 0;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		radix_mode = RADIX_DEC;
		push = 1'b0;
		character = '0;
		last_char = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, decimal straight out of reset: single digit, no digits,
		// underscore between digits, stop on a letter, stop on a colon,
		// characters just below zero and the byte extremes
		send_text("0");
		send_text("_");
		send_text("9_9");
		send_text("7a5");
		send_text("5:");
		send_text("/");
		send_char(8'h00, 1'b0, 1'b0);
		send_char(8'hFF, 1'b1, 1'b0);

		// hex letters in both cases, then letters beyond f
		drain_results();
		write_radix(RADIX_HEX);
		send_text("aF");
		send_text("Gg");

		// binary and octal with an underscore, then digits invalid in octal
		drain_results();
		write_radix(RADIX_BIN);
		send_text("1_0");
		drain_results();
		write_radix(RADIX_OCT);
		send_text("7_7");
		send_text("89");

		// random part: each radix in turn, then random settings
		while (sent < RANDOM_CHARS) begin
			m = (phases < 4) ? order[phases] : radix_t'($urandom_range(0, 3));
			drain_results();
			write_radix(m);
			phases++;
			phase_sent = 0;
			while (phase_sent < PHASE_CHARS && sent < RANDOM_CHARS) begin
				build_literal(m);
				send_literal();
				phase_sent += lit_chars.size();
				sent += lit_chars.size();
				// once, mid-phase, hold the request side until all is popped
				if (!held_once && phases == 3 && phase_sent >= PHASE_CHARS / 2) begin
					drain_results();
					held_once = 1;
				end
			end
		end

		drain_results();
		$display("%0d characters taken, %0d literals checked, %0d saturated",
			sb.chars_taken, sb.literals_checked, sb.sat_seen);
		$display("all four radix settings driven over %0d random phases, idle on both sides",
			phases);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
